// File: sv/irq_vector_allocator_macros.svh
// ----------------------------------------------------------------------------
// IRQ vector allocator assertion macros
// Concurrent assertion helpers, clocked on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef IRQ_VECTOR_ALLOCATOR_MACROS_SVH
`define IRQ_VECTOR_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define IVA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define IVA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IVA_ASSERT_NOW(label, ante, cons, msg)
`define IVA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/iva_pkg.sv
// ----------------------------------------------------------------------------
// IRQ vector allocator package
// Sizes, codes, state type and shared structures of the allocator.
// ----------------------------------------------------------------------------
package iva_pkg;

    // Table and core sizes.
    localparam int SLOT_COUNT = 64;
    localparam int CORE_COUNT = 4;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int CORE_IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int CORE_CNT_W = $clog2(CORE_COUNT + 1);
    localparam int LOAD_W     = 7;

    // Fixed values of the allocation scheme.
    localparam logic [7:0]        VECTOR_BASE    = 8'd32;
    localparam logic [7:0]        RESERVED_INDEX = 8'hFF;
    localparam logic [LOAD_W-1:0] LOAD_MAX       = 7'd127;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam logic [2:0] REG_CORES_IN_USE = 3'd0;
    localparam logic [2:0] REG_CORE0_ID     = 3'd1;
    localparam logic [2:0] REG_CORE1_ID     = 3'd2;
    localparam logic [2:0] REG_CORE2_ID     = 3'd3;
    localparam logic [2:0] REG_CORE3_ID     = 3'd4;

    // Result codes.
    typedef enum logic [1:0] {
        STATUS_HIT  = 2'd0,
        STATUS_NEW  = 2'd1,
        STATUS_FULL = 2'd2
    } iva_status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHOOSE,
        ST_WRITE,
        ST_DONE
    } iva_state_t;

    // One slot of the table.
    typedef struct packed {
        logic [7:0] irq;
        logic [7:0] dest;
    } iva_slot_t;

    // Access to the slot table.
    typedef struct packed {
        logic                  we;
        logic [SLOT_IDX_W-1:0] waddr;
        iva_slot_t             wdata;
        logic                  re;
        logic [SLOT_IDX_W-1:0] raddr;
    } iva_ram_req_t;

endpackage

// File: sv/iva_req_if.sv
// ----------------------------------------------------------------------------
// IRQ vector allocator request channel
// Valid/ready channel carrying one interrupt number per beat.
// ----------------------------------------------------------------------------
interface iva_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] irq_number;

    modport source (output valid, output irq_number, input ready);
    modport sink (input valid, input irq_number, output ready);
endinterface

// File: sv/iva_rsp_if.sv
// ----------------------------------------------------------------------------
// IRQ vector allocator response channel
// Valid/ready channel carrying one allocation result per beat.
// ----------------------------------------------------------------------------
interface iva_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] vector;
    logic [7:0] dest_id;
    logic [1:0] status;

    modport source (output valid, output vector, output dest_id, output status, input ready);
    modport sink (input valid, input vector, input dest_id, input status, output ready);
endinterface

// File: sv/iva_slot_store.sv
// ----------------------------------------------------------------------------
// IRQ vector allocator slot store
// Slot table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iva_slot_store
    import iva_pkg::*;
(
    input  logic         clk,
    input  iva_ram_req_t req,
    output iva_slot_t    rdata
);

    iva_slot_t mem [SLOT_COUNT];
    iva_slot_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, data appears the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/irq_vector_allocator.sv
// ----------------------------------------------------------------------------
// IRQ vector allocator
// Maps interrupt numbers to vectors and picks the least-loaded core.
// ----------------------------------------------------------------------------
// Usage:
// Each request beat on req carries an interrupt number. One response beat on
// rsp follows: an existing slot's vector and destination (status hit), a new
// slot with the least-loaded enabled core (status new), or table full.
// The slot table is walked one entry per cycle through the read port of the
// slot memory, then the enabled cores are compared one per cycle.
// The sequencer returns to idle, ready for the next request, when the result
// moves into the output register. One request is handled at a time;
// req.ready is low meanwhile. The result waits in an output register while
// rsp.ready is low; the next request may be accepted then, but its result is
// held back until the output register is free. Reset empties the table and
// clears all core loads; no clearing pass is needed. The user must see that
// configuration is written through the APB port only while idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
`include "irq_vector_allocator_macros.svh"

module irq_vector_allocator
    import iva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iva_req_if.sink            req,
    iva_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers.
    logic [2:0] cores_in_use_reg;
    logic [7:0] core_id_reg [4];

    // Sequencer and datapath registers.
    iva_state_t            state_reg, state_next;
    logic [7:0]            irq_reg, irq_next;
    logic [COUNT_W-1:0]    scan_reg, scan_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [SLOT_IDX_W-1:0] alloc_idx_reg, alloc_idx_next;
    logic [CORE_IDX_W-1:0] best_reg, best_next;
    logic [LOAD_W-1:0]     best_load_reg, best_load_next;
    logic [CORE_CNT_W-1:0] cidx_reg, cidx_next;
    logic [7:0]            res_vector_reg, res_vector_next;
    logic [7:0]            res_dest_reg, res_dest_next;
    iva_status_t           res_status_reg, res_status_next;
    logic [COUNT_W-1:0]    slots_used_reg, slots_used_next;
    logic [LOAD_W-1:0]     core_load_reg [CORE_COUNT];
    logic                  load_inc;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_vector_reg, out_vector_next;
    logic [7:0]            out_dest_reg, out_dest_next;
    iva_status_t           out_status_reg, out_status_next;

    // Slot memory access.
    iva_ram_req_t ram_req;
    iva_slot_t    ram_rdata;

    // Helpers.
    logic [CORE_CNT_W-1:0] active_cores;
    logic [7:0]            free_idx;
    logic [1:0]            best_sel;
    logic [7:0]            best_id;
    logic                  cfg_write;
    logic [2:0]            cfg_index;

    iva_slot_store u_slot_store (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cores_in_use_reg <= 3'd1;
            core_id_reg[0]   <= 8'd0;
            core_id_reg[1]   <= 8'd1;
            core_id_reg[2]   <= 8'd2;
            core_id_reg[3]   <= 8'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CORES_IN_USE: cores_in_use_reg <= pwdata[2:0];
                REG_CORE0_ID:     core_id_reg[0]   <= pwdata[7:0];
                REG_CORE1_ID:     core_id_reg[1]   <= pwdata[7:0];
                REG_CORE2_ID:     core_id_reg[2]   <= pwdata[7:0];
                REG_CORE3_ID:     core_id_reg[3]   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (cfg_index)
            REG_CORES_IN_USE: prdata = PDATA_W'(cores_in_use_reg);
            REG_CORE0_ID:     prdata = PDATA_W'(core_id_reg[0]);
            REG_CORE1_ID:     prdata = PDATA_W'(core_id_reg[1]);
            REG_CORE2_ID:     prdata = PDATA_W'(core_id_reg[2]);
            REG_CORE3_ID:     prdata = PDATA_W'(core_id_reg[3]);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Derived values.
    // ------------------------------------------------------------------

    // A core count of zero acts as one; counts above the core total are clamped.
    always_comb
    begin
        if (cores_in_use_reg == 3'd0)
        begin
            active_cores = CORE_CNT_W'(1);
        end
        else if (CORE_CNT_W'(cores_in_use_reg) > CORE_CNT_W'(CORE_COUNT))
        begin
            active_cores = CORE_CNT_W'(CORE_COUNT);
        end
        else
        begin
            active_cores = CORE_CNT_W'(cores_in_use_reg);
        end
    end

    // Next free slot; the reserved index is stepped over.
    always_comb
    begin
        free_idx = 8'(slots_used_reg);
        if (free_idx == RESERVED_INDEX)
        begin
            free_idx = free_idx + 8'd1;
        end
    end

    assign best_sel = 2'(best_reg);
    assign best_id  = core_id_reg[best_sel];

    // ------------------------------------------------------------------
    // State register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CORE_COUNT; c++)
            begin
                core_load_reg[c] <= '0;
            end
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            slots_used_reg <= slots_used_next;
            out_valid_reg  <= out_valid_next;
            if (load_inc && (best_load_reg < LOAD_MAX))
            begin
                core_load_reg[best_reg] <= best_load_reg + LOAD_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        irq_reg        <= irq_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        alloc_idx_reg  <= alloc_idx_next;
        best_reg       <= best_next;
        best_load_reg  <= best_load_next;
        cidx_reg       <= cidx_next;
        res_vector_reg <= res_vector_next;
        res_dest_reg   <= res_dest_next;
        res_status_reg <= res_status_next;
        out_vector_reg <= out_vector_next;
        out_dest_reg   <= out_dest_next;
        out_status_reg <= out_status_next;
    end

    // ------------------------------------------------------------------
    // Sequencer: search, core choice, table write, result hand-off.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        irq_next        = irq_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        alloc_idx_next  = alloc_idx_reg;
        best_next       = best_reg;
        best_load_next  = best_load_reg;
        cidx_next       = cidx_reg;
        res_vector_next = res_vector_reg;
        res_dest_next   = res_dest_reg;
        res_status_next = res_status_reg;
        slots_used_next = slots_used_reg;
        load_inc        = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_vector_next = out_vector_reg;
        out_dest_next   = out_dest_reg;
        out_status_next = out_status_reg;
        req.ready       = 1'b0;

        ram_req         = '0;
        ram_req.raddr   = scan_reg[SLOT_IDX_W-1:0];
        ram_req.waddr   = alloc_idx_reg;
        ram_req.wdata   = '{irq: irq_reg, dest: best_id};

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    irq_next        = req.irq_number;
                    scan_next       = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SEARCH;
                end
            end

            // Issue one slot read per cycle and compare the slot read before.
            ST_SEARCH:
            begin
                if (pend_valid_reg && (ram_rdata.irq == irq_reg))
                begin
                    res_vector_next = VECTOR_BASE + 8'(pend_idx_reg);
                    res_dest_next   = ram_rdata.dest;
                    res_status_next = STATUS_HIT;
                    pend_valid_next = 1'b0;
                    state_next      = ST_DONE;
                end
                else if (scan_reg < slots_used_reg)
                begin
                    ram_req.re      = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[SLOT_IDX_W-1:0];
                    scan_next       = scan_reg + COUNT_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    // No match anywhere: allocate, unless the table is full.
                    if (free_idx >= 8'(SLOT_COUNT))
                    begin
                        res_vector_next = 8'd0;
                        res_dest_next   = 8'd0;
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        alloc_idx_next = free_idx[SLOT_IDX_W-1:0];
                        best_next      = '0;
                        best_load_next = core_load_reg[0];
                        cidx_next      = CORE_CNT_W'(1);
                        state_next     = ST_CHOOSE;
                    end
                end
                else
                begin
                    pend_valid_next = 1'b0;
                end
            end

            // One core compared per cycle; a strictly lower load wins.
            ST_CHOOSE:
            begin
                if (cidx_reg < active_cores)
                begin
                    if (core_load_reg[cidx_reg[CORE_IDX_W-1:0]] < best_load_reg)
                    begin
                        best_next      = cidx_reg[CORE_IDX_W-1:0];
                        best_load_next = core_load_reg[cidx_reg[CORE_IDX_W-1:0]];
                    end
                    cidx_next = cidx_reg + CORE_CNT_W'(1);
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_req.we      = 1'b1;
                load_inc        = 1'b1;
                slots_used_next = COUNT_W'(8'(alloc_idx_reg) + 8'd1);
                res_vector_next = VECTOR_BASE + 8'(alloc_idx_reg);
                res_dest_next   = best_id;
                res_status_next = STATUS_NEW;
                state_next      = ST_DONE;
            end

            // Move the result into the output register once it is free.
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_vector_next = res_vector_reg;
                    out_dest_next   = res_dest_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.vector  = out_vector_reg;
    assign rsp.dest_id = out_dest_reg;
    assign rsp.status  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `IVA_ASSERT_NOW(a_used_in_range, 1'b1, slots_used_reg <= COUNT_W'(SLOT_COUNT), "slot count beyond table")
    `IVA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted twice in a row")
    `IVA_ASSERT_NEXT(a_done_hands_off, (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready), rsp.valid && (state_reg == ST_IDLE), "result not handed off")
    `IVA_ASSERT_NOW(a_vector_range, rsp.valid && (rsp.status != STATUS_FULL), (rsp.vector >= VECTOR_BASE) && (rsp.vector < VECTOR_BASE + 8'(SLOT_COUNT)), "vector outside slot range")
    `IVA_ASSERT_NOW(a_write_in_table, ram_req.we, slots_used_reg < COUNT_W'(SLOT_COUNT), "write to a full table")

endmodule

// File: dv/vector_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector allocation checker
// Watches the request, response and register ports of the allocator. It keeps
// its own slot table, core loads and register copies, predicts the result of
// every request beat and compares each response beat with the oldest one.
// ----------------------------------------------------------------------------
module vector_alloc_checker
    import iva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iva_req_if                 req,
    iva_rsp_if                 rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int unsigned        fail_count,
    output int unsigned        results_pending
);

    typedef struct packed {
        logic [7:0]  vector;
        logic [7:0]  dest_id;
        iva_status_t status;
    } alloc_t;

    // Shadow of the slot table, the core loads and the registers.
    logic [7:0]        slot_irq_copy  [SLOT_COUNT];
    logic [7:0]        slot_dest_copy [SLOT_COUNT];
    int unsigned       slots_taken;
    logic [LOAD_W-1:0] load_copy      [CORE_COUNT];
    logic [2:0]        cores_cfg;
    logic [7:0]        core_id_cfg    [4];

    alloc_t            expected_allocs [$];
    alloc_t            want;
    logic [2:0]        reg_idx;
    logic [PDATA_W-1:0] read_want;
    int unsigned       failures;

    // Works out the response to one interrupt number and updates the shadow
    // state as the allocator would.
    function automatic alloc_t predict_allocation(input logic [7:0] irq);
        alloc_t      res;
        int unsigned idx;
        int unsigned enabled;
        int unsigned best;
        res.vector  = 8'd0;
        res.dest_id = 8'd0;
        res.status  = STATUS_FULL;
        // An interrupt that already owns a slot gets that slot back.
        for (int unsigned s = 0; s < slots_taken; s++)
        begin
            if (slot_irq_copy[s] == irq)
            begin
                res.vector  = VECTOR_BASE + 8'(s);
                res.dest_id = slot_dest_copy[s];
                res.status  = STATUS_HIT;
                return res;
            end
        end
        idx = slots_taken;
        if (idx == RESERVED_INDEX)
            idx++;
        if (idx >= SLOT_COUNT)
            return res;
        // A core count of zero behaves as one; too large a count is clipped.
        enabled = (cores_cfg == 3'd0) ? 1 : cores_cfg;
        if (enabled > CORE_COUNT)
            enabled = CORE_COUNT;
        // Least-loaded enabled core, the lowest index winning a tie.
        best = 0;
        for (int unsigned c = 1; c < enabled; c++)
        begin
            if (load_copy[c] < load_copy[best])
                best = c;
        end
        slot_irq_copy[idx]  = irq;
        slot_dest_copy[idx] = core_id_cfg[best];
        if (load_copy[best] < LOAD_MAX)
            load_copy[best]++;
        slots_taken = idx + 1;
        res.vector  = VECTOR_BASE + 8'(idx);
        res.dest_id = core_id_cfg[best];
        res.status  = STATUS_NEW;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                slot_irq_copy[s]  = 8'd0;
                slot_dest_copy[s] = 8'd0;
            end
            for (int c = 0; c < CORE_COUNT; c++)
                load_copy[c] = '0;
            for (int c = 0; c < 4; c++)
                core_id_cfg[c] = 8'(c);
            slots_taken = 0;
            cores_cfg   = 3'd1;
            failures    = 0;
            expected_allocs.delete();
            fail_count      <= 0;
            results_pending <= 0;
        end
        else
        begin
            // Register port: writes update the copies, reads are checked.
            if (psel && penable && pready)
            begin
                reg_idx = paddr[PADDR_W-1:2];
                if (pwrite)
                begin
                    if (reg_idx == REG_CORES_IN_USE)
                        cores_cfg = pwdata[2:0];
                    else if (reg_idx >= REG_CORE0_ID && reg_idx <= REG_CORE3_ID)
                        core_id_cfg[reg_idx - REG_CORE0_ID] = pwdata[7:0];
                end
                else
                begin
                    case (reg_idx)
                        REG_CORES_IN_USE:
                            read_want = {29'd0, cores_cfg};
                        REG_CORE0_ID, REG_CORE1_ID, REG_CORE2_ID, REG_CORE3_ID:
                            read_want = {24'd0, core_id_cfg[reg_idx - REG_CORE0_ID]};
                        default:
                            read_want = prdata;
                    endcase
                    if (prdata !== read_want)
                    begin
                        $error("prdata of register %0d: expected %0h, got %0h",
                               reg_idx, read_want, prdata);
                        failures++;
                    end
                end
            end

            // Response beat against the oldest outstanding prediction.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_allocs.size() == 0)
                begin
                    $error("response beat with nothing outstanding: vector %0d, status %0d",
                           rsp.vector, rsp.status);
                    failures++;
                end
                else
                begin
                    want = expected_allocs.pop_front();
                    if (rsp.vector !== want.vector)
                    begin
                        $error("vector: expected %0d, got %0d", want.vector, rsp.vector);
                        failures++;
                    end
                    if (rsp.dest_id !== want.dest_id)
                    begin
                        $error("dest_id: expected %0d, got %0d", want.dest_id, rsp.dest_id);
                        failures++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        failures++;
                    end
                end
            end

            // Request beat: predict its response.
            if (req.valid && req.ready)
                expected_allocs.push_back(predict_allocation(req.irq_number));

            fail_count      <= failures;
            results_pending <= expected_allocs.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt vector allocator testbench
// Drives interrupt numbers and register settings into the allocator, with
// directed cases first and then random phases of sender and receiver idling.
// The checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module testbench;
    import iva_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    localparam int unsigned SETTLE_CYCLES   = 80;
    localparam int unsigned FRESH_PCT       = 10;
    // Register indexes beyond the defined set.
    localparam logic [2:0]  REG_SPARE_A     = 3'd5;
    localparam logic [2:0]  REG_SPARE_B     = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned        fail_count;
    int unsigned        results_pending;
    int unsigned        sender_idle_pct;
    int unsigned        receiver_stall_pct;
    int unsigned        quiet_cycles;
    bit                 hold_off_pending;
    bit                 irq_known [256];
    logic [7:0]         irq_log [$];

    iva_req_if req_ch ();
    iva_rsp_if rsp_ch ();

    irq_vector_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vector_alloc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles in which no beat moves on any port.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one interrupt number and returns at the edge that takes it.
    // Valid stays high so that the next beat can follow straight on.
    task automatic send_irq(input logic [7:0] irq);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.irq_number <= irq;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (!irq_known[irq])
        begin
            irq_known[irq] = 1'b1;
            irq_log.push_back(irq);
        end
    endtask

    // Stops offering and waits until every response has come back.
    task automatic rest_sender();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic reg_access(input bit is_write, input logic [2:0] idx,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes every register, with noise in the unused upper bits, then reads
    // each one back.
    task automatic apply_settings(input logic [2:0] cores, input logic [7:0] ids [4]);
        logic [PDATA_W-1:0] data;
        data      = $urandom();
        data[2:0] = cores;
        reg_access(1'b1, REG_CORES_IN_USE, data);
        for (int c = 0; c < 4; c++)
        begin
            data      = $urandom();
            data[7:0] = ids[c];
            reg_access(1'b1, REG_CORE0_ID + 3'(c), data);
        end
        for (int r = 0; r <= REG_CORE3_ID; r++)
            reg_access(1'b0, 3'(r), '0);
    endtask

    initial
    begin
        logic [7:0]  ids [4];
        logic [7:0]  irq;
        int unsigned phase;

        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.irq_number  = 8'd0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_pending   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a single core. Extreme numbers, then hits on them.
        send_irq(8'd0);
        send_irq(8'd255);
        send_irq(8'd0);
        send_irq(8'd255);
        rest_sender();

        // Four cores with extreme IDs: the loads even out, ties go low.
        ids = '{8'hFF, 8'h00, 8'hAA, 8'h55};
        apply_settings(3'd4, ids);
        for (int n = 1; n <= 7; n++)
            send_irq(8'(n));
        send_irq(8'd128);
        send_irq(8'd2);
        rest_sender();

        // A core count of zero acts as one.
        apply_settings(3'd0, ids);
        send_irq(8'd9);
        rest_sender();

        // A core count above the number of cores is clipped.
        apply_settings(3'd7, ids);
        send_irq(8'd10);
        send_irq(8'd11);
        rest_sender();

        // Writes to unknown registers change nothing.
        reg_access(1'b1, REG_SPARE_A, $urandom());
        reg_access(1'b1, REG_SPARE_B, $urandom());
        ids[1] = 8'h5A;
        apply_settings(3'd2, ids);
        send_irq(8'd12);
        send_irq(8'd13);
        send_irq(8'd255);
        send_irq(8'd0);

        // Random phases: mostly repeats of known numbers, some fresh ones.
        for (phase = 0; phase < 4; phase++)
        begin
            rest_sender();
            // Fill the table before the last phase so that it runs full.
            if (phase == 3)
            begin
                while (irq_log.size() < SLOT_COUNT + 4)
                begin
                    irq = 8'($urandom_range(0, 255));
                    if (!irq_known[irq])
                        send_irq(irq);
                end
                rest_sender();
            end
            for (int c = 0; c < 4; c++)
            begin
                case ($urandom_range(0, 3))
                    0:       ids[c] = 8'h00;
                    1:       ids[c] = 8'hFF;
                    default: ids[c] = 8'($urandom_range(0, 255));
                endcase
            end
            apply_settings(3'($urandom_range(0, 7)), ids);
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 47;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 47;
                end
                default:
                begin
                    sender_idle_pct    = 16;
                    receiver_stall_pct = 16;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (phase == 0 && n == 40)
                    hold_off_pending = 1'b1;
                if (irq_log.size() == 0 || $urandom_range(99) < FRESH_PCT)
                    irq = 8'($urandom_range(0, 255));
                else
                    irq = irq_log[$urandom_range(0, irq_log.size() - 1)];
                send_irq(irq);
            end
        end

        rest_sender();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/iva_pkg.sv
sv/iva_req_if.sv
sv/iva_rsp_if.sv
sv/iva_slot_store.sv
sv/irq_vector_allocator.sv
dv/vector_alloc_checker.sv
dv/testbench.sv
